// ----- sv/gibs_pkg.sv -----
// shared constants and types for the greedy iou box suppression block
package gibs_pkg;

    localparam int MAX_KEPT   = 64;
    localparam int COORD_BITS = 13;

    localparam int DIM_W   = 12;
    localparam int CLS_W   = 8;
    localparam int AREA_W  = 2 * DIM_W;
    localparam int UNI_W   = AREA_W + 1;
    localparam int THR_W   = 16;
    localparam int EDGE_W  = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W + 1) + 1;
    localparam int IDX_W   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNT_W   = $clog2(MAX_KEPT + 1);
    localparam int PIPE    = 3;
    localparam int STEP_W  = $clog2(MAX_KEPT + PIPE + 1);
    localparam int POS_W   = 12;
    localparam int TOT_W   = 7;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAX_KEPT + PIPE);
    localparam logic [POS_W-1:0]  POS_MAX   = {POS_W{1'b1}};
    localparam logic [THR_W-1:0]  THR_RESET = 16'd32768;

    localparam logic [1:0] ADDR_THR = 2'd0;

    // one stored box: upright sizes, unswapped area
    typedef struct packed {
        logic signed [COORD_BITS-1:0] left;
        logic signed [COORD_BITS-1:0] top;
        logic [DIM_W-1:0]             w;
        logic [DIM_W-1:0]             h;
        logic [CLS_W-1:0]             cls;
        logic [AREA_W-1:0]            area;
    } entry_t;

endpackage

// ----- sv/gibs_cell.sv -----
// one storage cell of the kept-box ring
module gibs_cell (
    input  logic            clk,
    input  logic            shift_en,
    input  logic            load_en,
    input  gibs_pkg::entry_t load_data,
    input  gibs_pkg::entry_t from_next,
    output gibs_pkg::entry_t data
);

    gibs_pkg::entry_t data_reg;

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            data_reg <= load_data;
        end
        else if (shift_en)
        begin
            data_reg <= from_next;
        end
    end

    assign data = data_reg;

endmodule

// ----- sv/gibs_cmp.sv -----
// pipelined overlap test of the candidate against the ring head
module gibs_cmp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  gibs_pkg::entry_t              cand,
    input  gibs_pkg::entry_t              head,
    input  logic [gibs_pkg::THR_W-1:0]    thr,
    output logic                          hit
);

    localparam int EW = gibs_pkg::EDGE_W;
    localparam int DW = gibs_pkg::DIM_W;

    logic signed [EW-1:0] a_l, a_r, a_t, a_b, b_l, b_r, b_t, b_b;
    logic signed [EW-1:0] x1, x2, y1, y2, dxs, dys;
    logic [DW-1:0] dx_next, dy_next;

    logic                          v1_reg, v2_reg, v3_reg;
    logic [DW-1:0]                 dx_reg, dy_reg;
    logic [gibs_pkg::UNI_W-1:0]    sum1_reg, sum2_reg, uni_reg;
    logic [gibs_pkg::AREA_W-1:0]   inter2_reg, inter3_reg;
    logic [gibs_pkg::UNI_W-1:0]    uni_next;
    logic [gibs_pkg::AREA_W+gibs_pkg::THR_W-1:0] lhs;
    logic [gibs_pkg::UNI_W+gibs_pkg::THR_W-1:0]  rhs;

    always_comb
    begin
        a_l = EW'(cand.left);
        a_t = EW'(cand.top);
        b_l = EW'(head.left);
        b_t = EW'(head.top);
        a_r = a_l + $signed(EW'(cand.w));
        a_b = a_t + $signed(EW'(cand.h));
        b_r = b_l + $signed(EW'(head.w));
        b_b = b_t + $signed(EW'(head.h));
        x1 = (a_l > b_l) ? a_l : b_l;
        y1 = (a_t > b_t) ? a_t : b_t;
        x2 = (a_r < b_r) ? a_r : b_r;
        y2 = (a_b < b_b) ? a_b : b_b;
        dxs = x2 - x1;
        dys = y2 - y1;
        // empty when edges touch or miss
        if ((x1 >= x2) || (y1 >= y2))
        begin
            dx_next = '0;
            dy_next = '0;
        end
        else
        begin
            dx_next = dxs[DW-1:0];
            dy_next = dys[DW-1:0];
        end
    end

    always_comb
    begin
        if (sum2_reg > gibs_pkg::UNI_W'(inter2_reg))
        begin
            uni_next = sum2_reg - gibs_pkg::UNI_W'(inter2_reg);
        end
        else
        begin
            uni_next = gibs_pkg::UNI_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid && (cand.cls == head.cls);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        sum1_reg   <= gibs_pkg::UNI_W'(cand.area) + gibs_pkg::UNI_W'(head.area);
        inter2_reg <= dx_reg * dy_reg;
        sum2_reg   <= sum1_reg;
        uni_reg    <= uni_next;
        inter3_reg <= inter2_reg;
    end

    assign lhs = {inter3_reg, {gibs_pkg::THR_W{1'b0}}};
    assign rhs = uni_reg * thr;
    assign hit = v3_reg && ((gibs_pkg::UNI_W + gibs_pkg::THR_W)'(lhs) > rhs);

endmodule

// ----- sv/greedy_iou_box_suppression.sv -----
// top level of the greedy iou box suppression block
// Boxes arrive one at a time, sorted by falling score; each is checked against
// every kept box of the same class and reported once with keep, its index in
// the frame, the kept count and an overflow flag. Kept boxes sit in a ring of
// MAX_KEPT register cells that rotates one place per cycle past a single
// three-stage overlap unit, so a box's result is ready once the ring has made
// its full turn, the overlap unit has drained and the output register is free.
// A result waits in an output register, so the next box may be taken while
// the last result is still held. The threshold is set over the apb port at
// address 0 and must only change while the block is idle.
module greedy_iou_box_suppression (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // apb configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [1:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 frame_start,
    input  logic signed [gibs_pkg::COORD_BITS-1:0] box_left,
    input  logic signed [gibs_pkg::COORD_BITS-1:0] box_top,
    input  logic [11:0]                          box_width,
    input  logic [11:0]                          box_height,
    input  logic [7:0]                           class_label,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 keep,
    output logic [11:0]                          box_index,
    output logic [6:0]                           kept_total,
    output logic                                 overflow
);

    localparam int M = gibs_pkg::MAX_KEPT;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic state_reg, state_next;

    // threshold register
    logic [gibs_pkg::THR_W-1:0] thr_reg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == gibs_pkg::ADDR_THR);
    assign prdata = (paddr == gibs_pkg::ADDR_THR) ? 32'(thr_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= gibs_pkg::THR_RESET;
        end
        else if (cfg_wr)
        begin
            thr_reg <= pwdata[gibs_pkg::THR_W-1:0];
        end
    end

    // handshake
    logic in_xfer, out_xfer, out_free, finish;
    logic [gibs_pkg::STEP_W-1:0] step_reg;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;
    assign out_free = !out_valid || !out_stall;
    assign finish   = (state_reg == ST_BUSY) && (step_reg == gibs_pkg::STEP_LAST) && out_free;

    // candidate box, upright sizes for the intersection
    gibs_pkg::entry_t cand_reg, cand_next;
    logic             swap;

    always_comb
    begin
        swap = {box_width, 1'b0} < {1'b0, box_height};
        cand_next.left = box_left;
        cand_next.top  = box_top;
        cand_next.w    = swap ? box_height : box_width;
        cand_next.h    = swap ? box_width : box_height;
        cand_next.cls  = class_label;
        cand_next.area = box_width * box_height;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cand_reg <= cand_next;
        end
    end

    // frame bookkeeping
    logic [gibs_pkg::CNT_W-1:0] count_reg;
    logic [gibs_pkg::POS_W-1:0] pos_reg, idx_reg;
    logic                       supp_reg;
    logic                       room, store;
    logic                       hit;

    assign room  = (count_reg < gibs_pkg::CNT_W'(M));
    assign store = finish && !supp_reg && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            count_reg <= '0;
            pos_reg   <= '0;
            supp_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_xfer)
            begin
                step_reg <= '0;
                supp_reg <= 1'b0;
                if (frame_start)
                begin
                    count_reg <= '0;
                    pos_reg   <= gibs_pkg::POS_W'(1);
                end
                else if (pos_reg != gibs_pkg::POS_MAX)
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
            else
            begin
                if ((state_reg == ST_BUSY) && (step_reg != gibs_pkg::STEP_LAST))
                begin
                    step_reg <= step_reg + 1'b1;
                end
                if (hit)
                begin
                    supp_reg <= 1'b1;
                end
                if (store)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            idx_reg <= frame_start ? '0 : pos_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_xfer) state_next = ST_BUSY;
            ST_BUSY: if (finish) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // ring of kept boxes; cell 0 is the head seen by the overlap unit
    gibs_pkg::entry_t cell_data [M];
    logic             rotate, feed_valid;

    assign rotate     = (state_reg == ST_BUSY) && (step_reg < gibs_pkg::STEP_W'(M));
    assign feed_valid = rotate && (step_reg < gibs_pkg::STEP_W'(count_reg));

    for (genvar i = 0; i < M; i++)
    begin : g_cell
        gibs_cell u_cell (
            .clk       (clk),
            .shift_en  (rotate),
            .load_en   (store && (count_reg[gibs_pkg::IDX_W-1:0] == gibs_pkg::IDX_W'(i))),
            .load_data (cand_reg),
            .from_next (cell_data[(i + 1) % M]),
            .data      (cell_data[i])
        );
    end

    gibs_cmp u_cmp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (feed_valid),
        .cand     (cand_reg),
        .head     (cell_data[0]),
        .thr      (thr_reg),
        .hit      (hit)
    );

    // result register
    logic                         out_valid_reg;
    logic                         keep_reg, ovf_reg;
    logic [gibs_pkg::POS_W-1:0]   index_reg;
    logic [gibs_pkg::TOT_W-1:0]   total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            keep_reg  <= !supp_reg;
            ovf_reg   <= !supp_reg && !room;
            index_reg <= idx_reg;
            total_reg <= gibs_pkg::TOT_W'(count_reg + gibs_pkg::CNT_W'(store));
        end
    end

    assign out_valid  = out_valid_reg;
    assign keep       = keep_reg;
    assign overflow   = ovf_reg;
    assign box_index  = index_reg;
    assign kept_total = total_reg;

endmodule

// ----- test/tb_greedy_iou_box_suppression.sv -----
// testbench for the greedy iou box suppression block: directed and random boxes
module tb_greedy_iou_box_suppression;

    // box as driven on the input side
    typedef struct {
        bit               fs;
        bit signed [12:0] left;
        bit signed [12:0] top;
        bit [11:0]        w;
        bit [11:0]        h;
        bit [7:0]         cls;
    } box_t;

    // verdict as seen on the output side
    typedef struct {
        bit        keep;
        bit [11:0] index;
        bit [6:0]  total;
        bit        ovf;
    } verdict_t;

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 0;
    logic in_stall;
    logic frame_start = 0;
    logic signed [12:0] box_left = '0, box_top = '0;
    logic [11:0] box_width = '0, box_height = '0;
    logic [7:0] class_label = '0;
    logic out_valid;
    logic out_stall = 0;
    logic keep;
    logic [11:0] box_index;
    logic [6:0] kept_total;
    logic overflow;

    always #6 clk = ~clk;

    greedy_iou_box_suppression u_top (.*);

    // predictor state: shadow of the kept store
    bit [15:0]        thr_shadow = 16'd32768;
    bit signed [31:0] st_left[gibs_pkg::MAX_KEPT], st_top[gibs_pkg::MAX_KEPT];
    bit [31:0]        st_w[gibs_pkg::MAX_KEPT], st_h[gibs_pkg::MAX_KEPT];
    bit [31:0]        st_area[gibs_pkg::MAX_KEPT];
    bit [7:0]         st_cls[gibs_pkg::MAX_KEPT];
    int               st_count = 0;
    int               frame_pos = 0;

    verdict_t verdicts_due[$];
    int  mismatches = 0;
    int  cycles = 0;
    int  sent = 0, checked = 0, kept_seen = 0, ovf_seen = 0;
    int  out_wait = 0;

    // intersection of two boxes, sizes turned upright first
    function automatic longint overlap_px(longint ax, longint ay, longint aw, longint ah,
                                          longint bx, longint by, longint bw, longint bh);
        longint t, x1, y1, x2, y2;
        if (aw * 2 < ah)
        begin
            t = aw; aw = ah; ah = t;
        end
        if (bw * 2 < bh)
        begin
            t = bw; bw = bh; bh = t;
        end
        x1 = (ax > bx) ? ax : bx;
        y1 = (ay > by) ? ay : by;
        x2 = (ax + aw < bx + bw) ? ax + aw : bx + bw;
        y2 = (ay + ah < by + bh) ? ay + ah : by + bh;
        if (x1 >= x2 || y1 >= y2) return 0;
        return (x2 - x1) * (y2 - y1);
    endfunction

    // judge one box against the shadow store and update it
    function automatic verdict_t judge_box(box_t b);
        verdict_t v;
        longint inter, uni, area;
        bit k;
        k = 1;
        area = longint'(b.w) * longint'(b.h);
        if (b.fs)
        begin
            st_count = 0;
            frame_pos = 0;
        end
        v.index = frame_pos[11:0];
        if (frame_pos < 4095) frame_pos++;
        for (int i = 0; i < st_count; i++)
        begin
            if (st_cls[i] == b.cls)
            begin
                inter = overlap_px(b.left, b.top, b.w, b.h,
                                   st_left[i], st_top[i], st_w[i], st_h[i]);
                uni = area + st_area[i];
                uni = (uni > inter) ? uni - inter : 0;
                if (uni < 1) uni = 1;
                if ((inter << 16) > longint'(thr_shadow) * uni) k = 0;
            end
        end
        v.ovf = 0;
        if (k)
        begin
            if (st_count < gibs_pkg::MAX_KEPT)
            begin
                st_left[st_count] = b.left;
                st_top[st_count]  = b.top;
                st_w[st_count]    = 32'(b.w);
                st_h[st_count]    = 32'(b.h);
                st_cls[st_count]  = b.cls;
                st_area[st_count] = 32'(area);
                st_count++;
            end
            else
            begin
                v.ovf = 1;
            end
        end
        v.keep  = k;
        v.total = st_count[6:0];
        return v;
    endfunction

    // send one box: random gap, then hold until the transfer; valid stays up
    // after the transfer until the next box or the drain takes it down
    task automatic send_box(box_t b);
        int gap;
        gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 17);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        frame_start <= b.fs;
        box_left    <= b.left;
        box_top     <= b.top;
        box_width   <= b.w;
        box_height  <= b.h;
        class_label <= b.cls;
        in_valid    <= 1;
        do @(posedge clk); while (in_stall);
        verdicts_due.insert(verdicts_due.size(), judge_box(b));
        sent++;
    endtask

    function automatic box_t make_box(bit fs, int l, int t, int w, int h, int c);
        box_t b;
        b.fs = fs;
        b.left = 13'(l);
        b.top = 13'(t);
        b.w = 12'(w);
        b.h = 12'(h);
        b.cls = 8'(c);
        return b;
    endfunction

    // clustered boxes so suppression actually happens
    function automatic box_t rand_box(int cx, int cy);
        box_t b;
        b.fs = ($urandom_range(0, 39) == 0);
        b.cls = 8'($urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0)
        begin
            b.left = 13'($urandom);
            b.top = 13'($urandom);
            b.w = 12'($urandom);
            b.h = 12'($urandom);
            b.cls = 8'($urandom);
        end
        else
        begin
            b.left = 13'(cx + $signed($urandom_range(0, 40)) - 20);
            b.top  = 13'(cy + $signed($urandom_range(0, 40)) - 20);
            b.w = 12'($urandom_range(0, 80));
            b.h = 12'($urandom_range(0, 80));
        end
        return b;
    endfunction

    // drop valid, wait for all verdicts, then for the block to go quiet
    task automatic drain;
        @(negedge clk);
        in_valid <= 0;
        wait (verdicts_due.size() == 0);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_threshold(bit [15:0] v);
        @(negedge clk);
        psel <= 1;
        pwrite <= 1;
        paddr <= gibs_pkg::ADDR_THR;
        pwdata <= {16'd0, v};
        @(negedge clk);
        penable <= 1;
        do @(posedge clk); while (!pready);
        thr_shadow = v;
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    // extremes of the fields and every special case
    task automatic test_directed;
        send_box(make_box(1, 0, 0, 10, 10, 1));
        send_box(make_box(0, 0, 0, 10, 10, 1));        // identical, suppressed
        send_box(make_box(0, 0, 0, 10, 10, 2));        // other class kept
        send_box(make_box(0, 10, 0, 10, 10, 1));       // edges touch
        send_box(make_box(0, 5, 0, 10, 10, 1));        // partial overlap
        send_box(make_box(0, 0, 0, 0, 0, 1));          // zero union
        send_box(make_box(0, 0, 0, 0, 0, 1));
        send_box(make_box(0, 0, 0, 3, 40, 1));         // tall box swapped
        send_box(make_box(0, 0, 0, 40, 3, 1));
        send_box(make_box(0, -4096, -4096, 4095, 4095, 255));
        send_box(make_box(0, 4095, 4095, 4095, 4095, 255));
        send_box(make_box(0, -4096, -4096, 4095, 4095, 255));
        send_box(make_box(0, -1, -1, 2, 2, 0));
        send_box(make_box(1, 100, 100, 20, 20, 3));    // frame restart
        send_box(make_box(0, 100, 100, 20, 20, 3));
        // fill the store to force overflow
        for (int i = 0; i < gibs_pkg::MAX_KEPT + 3; i++)
            send_box(make_box(0, -2000 + i * 50, 1000, 10, 10, 7));
        drain();
    endtask

    task automatic test_threshold(bit [15:0] v, int n);
        int cx, cy;
        write_threshold(v);
        cx = $urandom_range(0, 400);
        cy = $urandom_range(0, 400);
        for (int i = 0; i < n; i++)
        begin
            if (i % 30 == 0)
            begin
                cx = $signed($urandom_range(0, 8000)) - 4000;
                cy = $signed($urandom_range(0, 8000)) - 4000;
            end
            send_box(rand_box(cx, cy));
        end
        drain();
    endtask

    // one frame with a long run of small neighbors of one class
    task automatic test_saturation;
        send_box(make_box(1, 0, 0, 1, 1, 9));
        for (int i = 0; i < 40; i++)
            send_box(make_box(0, i * 3, 0, 2, 2, 9));
        drain();
    endtask

    // output side stalls after each result transfer for a randomly drawn number of cycles
    always @(negedge clk)
    begin
        out_stall <= (out_wait > 0);
        if (out_wait > 0) out_wait--;
    end

    // compare every result transfer with the oldest expectation
    always @(posedge clk)
    begin
        verdict_t exp_v;
        if (rst_n && out_valid && !out_stall)
        begin
            checked++;
            out_wait = $urandom_range(0, 17);
            if (verdicts_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer");
            end
            else
            begin
                exp_v = verdicts_due.pop_front();
                kept_seen += keep;
                ovf_seen += overflow;
                if (keep !== exp_v.keep || box_index !== exp_v.index ||
                    kept_total !== exp_v.total || overflow !== exp_v.ovf)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp k=%0d i=%0d t=%0d o=%0d got k=%0d i=%0d t=%0d o=%0d",
                                 exp_v.keep, exp_v.index, exp_v.total, exp_v.ovf,
                                 keep, box_index, kept_total, overflow);
                end
            end
        end
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 600000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1;
        repeat (2) @(negedge clk);
        test_directed();
        test_threshold(16'd0, 60);
        test_threshold(16'd65535, 60);
        test_threshold(16'd32768, 60);
        test_threshold(16'd9000, 100);
        test_saturation();
        $display("covered %0d boxes, %0d results, %0d kept, %0d overflow",
                 sent, checked, kept_seen, ovf_seen);
        if (mismatches == 0 && verdicts_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ----- files.f -----
sv/gibs_pkg.sv
sv/gibs_cell.sv
sv/gibs_cmp.sv
sv/greedy_iou_box_suppression.sv
test/tb_greedy_iou_box_suppression.sv
